// ===== hw/rtl/stsr_pkg.sv =====
package stsr_pkg;

   // Field widths fixed by the interface
   localparam int POS_W  = 17;
   localparam int DATA_W = 32;

   // Default tree size and command queue depth
   localparam int MAX_LEAVES_DEFAULT = 65536;
   localparam int CMDQ_DEPTH         = 2;

   // Input item kinds
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_ADD   = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   // Commands handed from the front to the tree engine
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ADD,
      OP_QUERY,
      OP_QERR
   } op_type;

   // Tree engine states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_WALK,
      ST_QUERY
   } back_state_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] amount;
      logic [POS_W-1:0]         first_index;
      logic [POS_W-1:0]         last_index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] range_sum;
      logic                     range_error;
   } rsp_type;

   // For writes, first carries the position
   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] amount;
      logic [POS_W-1:0]  first;
      logic [POS_W-1:0]  last;
   } cmd_type;

endpackage

// ===== hw/rtl/stsr_front.sv =====
module stsr_front #(
   parameter int MAX_LEAVES = stsr_pkg::MAX_LEAVES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  stsr_pkg::req_type         req_data,
   output logic                      req_full,
   input  logic                      csr_we,
   input  logic [stsr_pkg::POS_W-1:0] csr_wdata,
   input  logic                      q_full,
   input  logic                      clearing,
   output logic                      q_push,
   output stsr_pkg::cmd_type         q_data
);
   import stsr_pkg::*;

   localparam int LW = $clog2(MAX_LEAVES + 1);
   localparam int CW = (POS_W > LW) ? POS_W : LW;

   logic [POS_W-1:0] num_elements_ff;
   logic             pos_ok;
   logic             range_ok;
   logic             keep;

   // Hold the size register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_elements_ff <= POS_W'(1);
      end else if (csr_we) begin
         num_elements_ff <= csr_wdata;
      end
   end

   // Check positions against the size in use
   assign pos_ok = (req_data.position != '0)
                   && (req_data.position <= num_elements_ff)
                   && (CW'(req_data.position) <= CW'(MAX_LEAVES));
   assign range_ok = (req_data.first_index != '0)
                     && (req_data.last_index <= num_elements_ff)
                     && (CW'(req_data.last_index) <= CW'(MAX_LEAVES))
                     && (req_data.first_index <= req_data.last_index);

   // Classify the beat; drop bad writes and unused kinds here
   always_comb begin
      keep          = 1'b0;
      q_data.op     = OP_LOAD;
      q_data.amount = req_data.amount;
      q_data.first  = req_data.first_index;
      q_data.last   = req_data.last_index;
      case (req_data.kind)
         KIND_LOAD, KIND_ADD: begin
            keep         = pos_ok;
            q_data.op    = (req_data.kind == KIND_ADD) ? OP_ADD : OP_LOAD;
            q_data.first = req_data.position;
         end
         KIND_QUERY: begin
            keep      = 1'b1;
            q_data.op = range_ok ? OP_QUERY : OP_QERR;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_full = q_full || clearing;
   assign q_push   = req_push && !req_full && keep;

endmodule

// ===== hw/rtl/stsr_cmdq.sv =====
module stsr_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stsr_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output stsr_pkg::cmd_type pop_data
);
   import stsr_pkg::*;

   localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int NW = $clog2(CMDQ_DEPTH + 1);

   cmd_type         slots [CMDQ_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == NW'(CMDQ_DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = slots[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/stsr_back.sv =====
module stsr_back #(
   parameter int MAX_LEAVES = stsr_pkg::MAX_LEAVES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  stsr_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              clearing,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output stsr_pkg::rsp_type rsp_data
);
   import stsr_pkg::*;

   localparam int NODES = 2 * MAX_LEAVES;
   localparam int AW    = $clog2(NODES);
   localparam int NW    = $clog2(NODES + 1);

   logic [DATA_W-1:0] mem [NODES];
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]     rd_a_addr, rd_b_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;

   back_state_type    state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [NW-1:0]     hi_ff, hi_in;
   logic [DATA_W-1:0] cur_ff, cur_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pend_a_ff, pend_a_in;
   logic              pend_b_ff, pend_b_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] amount_ff, amount_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_free;
   logic [NW-1:0]     leaf_node;
   logic [NW-1:0]     hi_node;
   logic [NW-1:0]     sib_node;
   logic [NW-1:0]     parent;
   logic [NW-1:0]     sib_parent;
   logic [NW-1:0]     hi_dec;
   logic [DATA_W-1:0] leaf_val;
   logic [DATA_W-1:0] walk_sum;
   logic [DATA_W-1:0] acc_sum;

   // Node index arithmetic
   assign leaf_node  = NW'(MAX_LEAVES) + NW'(cmd_data.first) - NW'(1);
   assign hi_node    = NW'(MAX_LEAVES) + NW'(cmd_data.last);
   assign sib_node   = node_ff ^ NW'(1);
   assign parent     = node_ff >> 1;
   assign sib_parent = parent ^ NW'(1);
   assign hi_dec     = hi_ff - NW'(1);
   assign leaf_val   = (op_ff == OP_ADD) ? rd_a_ff + amount_ff : amount_ff;
   assign walk_sum   = cur_ff + rd_a_ff;
   assign acc_sum    = acc_ff + (pend_a_ff ? rd_a_ff : '0) + (pend_b_ff ? rd_b_ff : '0);
   assign out_free   = !out_valid_ff || rsp_pop;

   // Sequence the tree walks
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      hi_in        = hi_ff;
      cur_in       = cur_ff;
      acc_in       = acc_ff;
      pend_a_in    = pend_a_ff;
      pend_b_in    = pend_b_ff;
      op_in        = op_ff;
      amount_in    = amount_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_a_addr    = '0;
      rd_b_addr    = '0;
      cmd_pop      = 1'b0;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.op)
                  OP_LOAD, OP_ADD: begin
                     cmd_pop   = 1'b1;
                     node_in   = leaf_node;
                     op_in     = cmd_data.op;
                     amount_in = cmd_data.amount;
                     rd_a_addr = leaf_node[AW-1:0];
                     state_in  = ST_UPD_LEAF;
                  end
                  OP_QUERY: begin
                     if (out_free) begin
                        cmd_pop   = 1'b1;
                        node_in   = leaf_node;
                        hi_in     = hi_node;
                        acc_in    = '0;
                        pend_a_in = 1'b0;
                        pend_b_in = 1'b0;
                        state_in  = ST_QUERY;
                     end
                  end
                  OP_QERR: begin
                     if (out_free) begin
                        cmd_pop            = 1'b1;
                        out_valid_in       = 1'b1;
                        out_in.range_sum   = '0;
                        out_in.range_error = 1'b1;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b0;
                  end
               endcase
            end
         end
         ST_UPD_LEAF: begin
            // Write the leaf, fetch its sibling
            wr_en     = 1'b1;
            wr_addr   = node_ff[AW-1:0];
            wr_data   = leaf_val;
            cur_in    = leaf_val;
            rd_a_addr = sib_node[AW-1:0];
            state_in  = ST_UPD_WALK;
         end
         ST_UPD_WALK: begin
            // Write the parent, fetch the parent's sibling
            wr_en   = 1'b1;
            wr_addr = parent[AW-1:0];
            wr_data = walk_sum;
            cur_in  = walk_sum;
            node_in = parent;
            if (parent > NW'(1)) begin
               rd_a_addr = sib_parent[AW-1:0];
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            // Fold in last level's reads, issue the next level's
            acc_in = acc_sum;
            if (node_ff < hi_ff) begin
               pend_a_in = node_ff[0];
               pend_b_in = hi_ff[0];
               rd_a_addr = node_ff[AW-1:0];
               rd_b_addr = hi_dec[AW-1:0];
               node_in   = (node_ff + NW'(node_ff[0])) >> 1;
               hi_in     = (hi_ff - NW'(hi_ff[0])) >> 1;
            end else begin
               out_valid_in       = 1'b1;
               out_in.range_sum   = acc_sum;
               out_in.range_error = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff   <= node_in;
      hi_ff     <= hi_in;
      cur_ff    <= cur_in;
      acc_ff    <= acc_in;
      pend_a_ff <= pend_a_in;
      pend_b_ff <= pend_b_in;
      op_ff     <= op_in;
      amount_ff <= amount_in;
      out_ff    <= out_in;
   end

   // Node store: one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== hw/rtl/segment_tree_range_sum_top.sv =====
// Load/add: the engine writes the leaf, then each parent up to the root (17 tree
// levels at the default size, one level a cycle: the node store's registered read
// sets the pace). Query: both reads of a level share one cycle. Rejected writes and
// unused kinds leave at one per cycle while req_full is low. Reset is synchronous;
// the store is then zeroed one node a cycle, all 2*MAX_LEAVES nodes (131072 by
// default), with req_full high; size writes are still taken.
module segment_tree_range_sum_top #(
   parameter int MAX_LEAVES = stsr_pkg::MAX_LEAVES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  stsr_pkg::req_type          req_data,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output stsr_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [stsr_pkg::POS_W-1:0] csr_wdata
);
   import stsr_pkg::*;

   logic    q_push;
   cmd_type q_push_data;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_pop_data;
   logic    clearing;

   // Accept and classify beats
   stsr_front #(
      .MAX_LEAVES(MAX_LEAVES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .clearing  (clearing),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // Decouple front and engine
   stsr_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   // Walk the tree
   stsr_back #(
      .MAX_LEAVES(MAX_LEAVES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_data  (q_pop_data),
      .cmd_pop   (q_pop),
      .clearing  (clearing),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
